[sv/ibl_pkg.sv]
// ----------------------------------------------------------------------------
// IO board liveness monitor package
// Shared widths, codes, limits and record types for the liveness monitor.
// ----------------------------------------------------------------------------
package ibl_pkg;

   // Field widths.
   localparam int unsigned BOARD_ID_W  = 8;
   localparam int unsigned TICK_STEP_W = 10;
   localparam int unsigned PERIOD_W    = 16;
   localparam int unsigned MISS_W      = 8;
   localparam int unsigned WAIT_W      = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   // Miss handling limits.
   localparam logic [MISS_W-1:0]   MISS_ALARM_LIMIT = 8'd3;
   localparam logic [MISS_W-1:0]   MISS_MAX         = 8'hFF;
   localparam logic [WAIT_W-1:0]   WAIT_LIMIT       = 3'd5;
   localparam logic [PERIOD_W-1:0] ELAPSED_MAX      = 16'hFFFF;

   // Register reset values.
   localparam logic [TICK_STEP_W-1:0] TICK_STEP_RESET    = 10'd10;
   localparam logic [PERIOD_W-1:0]    CHECK_PERIOD_RESET = 16'd10;

   // Request kinds; the fourth code is unused and ignored.
   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_LIVE  = 2'd1,
      OP_CHECK = 2'd2
   } op_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_PRESENT      = 2'd0,
      CSR_EXPECTED_ID  = 2'd1,
      CSR_TICK_STEP    = 2'd2,
      CSR_CHECK_PERIOD = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                   present;
      logic [BOARD_ID_W-1:0]  expected_id;
      logic [TICK_STEP_W-1:0] tick_step;
      logic [PERIOD_W-1:0]    check_period;
   } cfg_type;

   typedef struct packed {
      logic [PERIOD_W-1:0]   elapsed_ms;
      logic [BOARD_ID_W-1:0] live_id;
      logic [BOARD_ID_W-1:0] probe_id;
      logic [MISS_W-1:0]     misses;
      logic                  alarm;
      logic [WAIT_W-1:0]     wait_count;
      logic                  probing;
   } state_type;

   typedef struct packed {
      op_type                op;
      logic [BOARD_ID_W-1:0] board_id;
      logic                  update_busy;
   } req_type;

   typedef struct packed {
      logic              send_probe;
      logic              send_reassign;
      logic              send_read_request;
      logic              response_error;
      logic [MISS_W-1:0] miss_count;
   } rsp_type;

endpackage

[sv/ibl_csr.sv]
// ----------------------------------------------------------------------------
// IO board liveness monitor configuration registers
// Holds board presence, expected id, tick step and check period.
// ----------------------------------------------------------------------------
module ibl_csr import ibl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic                  csr_ready,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken.
   assign csr_ready = 1'b1;

   // Select the register being written and keep the low bits of the data.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PRESENT:      cfg_in.present      = csr_data[0];
            CSR_EXPECTED_ID:  cfg_in.expected_id  = csr_data[BOARD_ID_W-1:0];
            CSR_TICK_STEP:    cfg_in.tick_step    = csr_data[TICK_STEP_W-1:0];
            CSR_CHECK_PERIOD: cfg_in.check_period = csr_data[PERIOD_W-1:0];
         endcase
      end
   end

   // Register bank.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.present      <= 1'b0;
         cfg_ff.expected_id  <= '0;
         cfg_ff.tick_step    <= TICK_STEP_RESET;
         cfg_ff.check_period <= CHECK_PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[sv/ibl_step.sv]
// ----------------------------------------------------------------------------
// IO board liveness monitor update logic
// Works out the next monitor state and the response for one request.
// ----------------------------------------------------------------------------
module ibl_step import ibl_pkg::*; (
   input  cfg_type   cfg,
   input  state_type cur,
   input  req_type   req,
   output state_type nxt,
   output rsp_type   rsp
);

   logic [PERIOD_W:0]     elapsed_sum;
   logic [MISS_W-1:0]     misses_inc;
   logic [WAIT_W-1:0]     wait_inc;
   logic                  probe;
   logic                  reassign;
   logic                  read_req;

   // Increments used on the tick path; the miss count saturates, and the timer sum keeps a carry bit.
   assign elapsed_sum = {1'b0, cur.elapsed_ms}
                      + {{(PERIOD_W + 1 - TICK_STEP_W){1'b0}}, cfg.tick_step};
   assign misses_inc  = (cur.misses != MISS_MAX) ? cur.misses + 8'd1 : cur.misses;
   assign wait_inc    = cur.wait_count + 3'd1;

   // Next state and transmission requests.
   always_comb begin
      nxt      = cur;
      probe    = 1'b0;
      reassign = 1'b0;
      read_req = 1'b0;
      if (cfg.present) begin
         unique case (req.op)
            OP_LIVE: begin
               nxt.live_id = req.board_id;
            end
            OP_CHECK: begin
               if (cur.probing) begin
                  nxt.probe_id = req.board_id;
               end
            end
            OP_TICK: begin
               if (cur.elapsed_ms >= cfg.check_period) begin
                  nxt.elapsed_ms = '0;
                  if (!req.update_busy) begin
                     read_req = 1'b1;
                     if (cur.live_id == cfg.expected_id) begin
                        // A good reply releases the alarm.
                        if (cur.alarm) begin
                           nxt.misses = '0;
                           nxt.alarm  = 1'b0;
                        end
                     end else begin
                        nxt.misses = misses_inc;
                        if (misses_inc >= MISS_ALARM_LIMIT) begin
                           nxt.alarm = 1'b1;
                        end
                        nxt.wait_count = wait_inc;
                        if (wait_inc >= WAIT_LIMIT) begin
                           // Every fifth miss: probe, or act on the probe answer.
                           nxt.wait_count = '0;
                           if (!cur.probing) begin
                              probe        = 1'b1;
                              nxt.probe_id = '0;
                              nxt.probing  = 1'b1;
                              read_req     = 1'b0;
                           end else begin
                              reassign    = (cur.probe_id == cfg.expected_id);
                              nxt.probing = 1'b0;
                           end
                        end
                     end
                     if (read_req) begin
                        nxt.live_id = '0;
                     end
                  end
               end else begin
                  nxt.elapsed_ms = elapsed_sum[PERIOD_W] ? ELAPSED_MAX
                                                         : elapsed_sum[PERIOD_W-1:0];
               end
            end
            default: begin
               // Unused request code: nothing changes.
            end
         endcase
      end
   end

   // Response record.
   assign rsp.send_probe        = probe;
   assign rsp.send_reassign     = reassign;
   assign rsp.send_read_request = read_req;
   assign rsp.response_error    = nxt.alarm;
   assign rsp.miss_count        = nxt.misses;

endmodule

[sv/io_board_liveness_monitor.sv]
// ----------------------------------------------------------------------------
// IO board liveness monitor
// Counts missed replies from a remote IO board, raises a response alarm and
// requests probe, re-assign and data-read transmissions.
// ----------------------------------------------------------------------------
//   Channel   Direction   Handshake              Carries
//   req_      in          req_valid/req_ready    op, board id, update busy
//   rsp_      out         rsp_valid/rsp_ready    send flags, alarm, miss count
//   csr_      in          csr_valid/csr_ready    register index, write data
//
// One request is accepted per cycle unless a stalled response holds the
// pipeline. The input register loads at the accepting edge, and the update
// then loads the response register, which makes the response valid. The
// monitor state updates in the same cycle as the response register loads.
// A stalled response holds the pipeline; the input register keeps taking
// requests while it is empty or moving on. Reset is synchronous, clears the
// valid flags and the monitor state and resets the configuration registers.
// ----------------------------------------------------------------------------
module io_board_liveness_monitor import ibl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_op,
   input  logic [BOARD_ID_W-1:0] req_board_id,
   input  logic                  req_update_busy,
   // Response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_send_probe,
   output logic                  rsp_send_reassign,
   output logic                  rsp_send_read_request,
   output logic                  rsp_response_error,
   output logic [MISS_W-1:0]     rsp_miss_count,
   // Configuration channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type   cfg;
   req_type   req_ff;
   req_type   req_in;
   logic      req_valid_ff;
   state_type state_ff;
   state_type state_in;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   logic      rsp_valid_ff;
   logic      advance;

   // Configuration registers.
   ibl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index_type'(csr_index)),
      .csr_data  (csr_data),
      .csr_ready (csr_ready),
      .cfg       (cfg)
   );

   // Update logic between the input register and the response register.
   ibl_step u_step (
      .cfg (cfg),
      .cur (state_ff),
      .req (req_ff),
      .nxt (state_in),
      .rsp (rsp_in)
   );

   // Pipeline flow control.
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;

   assign req_in.op          = op_type'(req_op);
   assign req_in.board_id    = req_board_id;
   assign req_in.update_busy = req_update_busy;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_in;
      end
   end

   // Monitor state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_send_probe        = rsp_ff.send_probe;
   assign rsp_send_reassign     = rsp_ff.send_reassign;
   assign rsp_send_read_request = rsp_ff.send_read_request;
   assign rsp_response_error    = rsp_ff.response_error;
   assign rsp_miss_count        = rsp_ff.miss_count;

   // A probe is never sent together with a re-assign or a data read.
   a_probe_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_probe |-> !rsp_send_reassign && !rsp_send_read_request)
      else $error("probe sent together with another transmission");

   // The alarm only stands once enough misses have been counted.
   a_alarm_misses: assert property (@(posedge clock) disable iff (reset)
      state_ff.alarm |-> state_ff.misses >= MISS_ALARM_LIMIT)
      else $error("alarm raised with too few misses");

   // A re-assign only follows an outstanding probe.
   a_reassign_probe: assert property (@(posedge clock) disable iff (reset)
      advance && rsp_in.send_reassign |-> state_ff.probing)
      else $error("re-assign without an outstanding probe");

endmodule

[tb/io_board_liveness_monitor_tb.sv]
// ----------------------------------------------------------------------------
// IO board liveness monitor testbench
// Drives ticks, live replies, board-check replies and unused codes into the monitor with
// random idling on both channels. Each accepted request is run through a
// local model of the monitor, and every response is compared field by field
// with the oldest prediction. A short directed table comes first, followed
// by random phases under several register settings.
// ----------------------------------------------------------------------------
module io_board_liveness_monitor_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ibl_pkg::*;

   // The fourth request code has no meaning and must be ignored.
   localparam logic [1:0]  OP_UNUSED      = 2'd3;
   localparam int unsigned IDLE_MAX       = 9;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned NUM_PHASES     = 10;
   localparam int unsigned STARVE_ITEMS   = 400;
   localparam int unsigned PHASE_ITEMS    = 105;

   typedef struct packed {
      logic [1:0]            op;
      logic [BOARD_ID_W-1:0] board_id;
      logic                  update_busy;
   } request_type;

   // One line of the directed table: either a register setting or a request,
   // the latter optionally with its response written out by hand.
   typedef struct packed {
      logic        is_cfg;
      cfg_type     cfg;
      request_type req;
      logic        typed;
      rsp_type     rsp;
   } plan_row_type;

   logic                  clock           = 1'b0;
   logic                  reset           = 1'b1;
   logic                  req_valid       = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_op          = OP_TICK;
   logic [BOARD_ID_W-1:0] req_board_id    = '0;
   logic                  req_update_busy = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready       = 1'b0;
   logic                  rsp_send_probe;
   logic                  rsp_send_reassign;
   logic                  rsp_send_read_request;
   logic                  rsp_response_error;
   logic [MISS_W-1:0]     rsp_miss_count;
   logic                  csr_valid       = 1'b0;
   logic                  csr_ready;
   logic [1:0]            csr_index       = CSR_PRESENT;
   logic [CSR_DATA_W-1:0] csr_data        = '0;

   // Local copy of the monitor's registers and state.
   cfg_type      board_cfg;
   state_type    board_state;
   logic         alarm_out;
   rsp_type      pending_rsp[$];
   plan_row_type directed_plan[$];
   int unsigned  error_count = 0;
   logic         send_calm   = 1'b0;
   logic         take_calm   = 1'b0;
   int unsigned  take_hold   = 0;

   io_board_liveness_monitor u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_op                (req_op),
      .req_board_id          (req_board_id),
      .req_update_busy       (req_update_busy),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_send_probe        (rsp_send_probe),
      .rsp_send_reassign     (rsp_send_reassign),
      .rsp_send_read_request (rsp_send_read_request),
      .rsp_response_error    (rsp_response_error),
      .rsp_miss_count        (rsp_miss_count),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Works out the response to one request and advances the local state.
   function automatic rsp_type monitor_response(request_type r);
      rsp_type           o;
      logic              send_read;
      logic [PERIOD_W:0] sum;
      o = '0;
      if (board_cfg.present) begin
         case (r.op)
            OP_LIVE: begin
               board_state.live_id = r.board_id;
            end
            OP_CHECK: begin
               // A check reply only counts while a probe is outstanding.
               if (board_state.probing)
                  board_state.probe_id = r.board_id;
            end
            OP_TICK: begin
               if (board_state.elapsed_ms >= board_cfg.check_period) begin
                  board_state.elapsed_ms = '0;
                  if (!r.update_busy) begin
                     send_read = 1'b1;
                     if (board_state.live_id == board_cfg.expected_id) begin
                        if (board_state.alarm) begin
                           alarm_out          = 1'b0;
                           board_state.misses = '0;
                           board_state.alarm  = 1'b0;
                        end
                     end else begin
                        if (board_state.misses != MISS_MAX)
                           board_state.misses = board_state.misses + 8'd1;
                        if (!board_state.alarm && board_state.misses >= MISS_ALARM_LIMIT) begin
                           alarm_out         = 1'b1;
                           board_state.alarm = 1'b1;
                        end
                        board_state.wait_count = board_state.wait_count + 3'd1;
                        if (board_state.wait_count >= WAIT_LIMIT) begin
                           board_state.wait_count = '0;
                           if (!board_state.probing) begin
                              // The probe goes out alone; the live id is kept.
                              o.send_probe         = 1'b1;
                              board_state.probe_id = '0;
                              board_state.probing  = 1'b1;
                              send_read            = 1'b0;
                           end else begin
                              if (board_state.probe_id == board_cfg.expected_id)
                                 o.send_reassign = 1'b1;
                              board_state.probing = 1'b0;
                           end
                        end
                     end
                     if (send_read) begin
                        board_state.live_id = '0;
                        o.send_read_request = 1'b1;
                     end
                  end
               end else begin
                  // The timer saturates rather than wrapping.
                  sum = {1'b0, board_state.elapsed_ms}
                      + {{(PERIOD_W + 1 - TICK_STEP_W){1'b0}}, board_cfg.tick_step};
                  if (sum > {1'b0, ELAPSED_MAX})
                     board_state.elapsed_ms = ELAPSED_MAX;
                  else
                     board_state.elapsed_ms = sum[PERIOD_W-1:0];
               end
            end
            default: ;
         endcase
      end
      o.response_error = alarm_out;
      o.miss_count     = board_state.misses;
      return o;
   endfunction

   function automatic int unsigned sender_gap();
      return send_calm ? 0 : $urandom_range(0, IDLE_MAX);
   endfunction

   function automatic int unsigned receiver_gap();
      return take_calm ? 0 : $urandom_range(0, IDLE_MAX);
   endfunction

   function automatic plan_row_type cfg_row(logic present, logic [BOARD_ID_W-1:0] exp_id,
                                            logic [TICK_STEP_W-1:0] step,
                                            logic [PERIOD_W-1:0] period);
      plan_row_type row;
      row                  = '0;
      row.is_cfg           = 1'b1;
      row.cfg.present      = present;
      row.cfg.expected_id  = exp_id;
      row.cfg.tick_step    = step;
      row.cfg.check_period = period;
      return row;
   endfunction

   function automatic plan_row_type req_row(logic [1:0] op, logic [BOARD_ID_W-1:0] id,
                                            logic busy);
      plan_row_type row;
      row                 = '0;
      row.req.op          = op;
      row.req.board_id    = id;
      row.req.update_busy = busy;
      return row;
   endfunction

   function automatic plan_row_type typed_row(logic [1:0] op, logic [BOARD_ID_W-1:0] id,
                                              logic busy, logic probe, logic reassign,
                                              logic readreq, logic err,
                                              logic [MISS_W-1:0] misses);
      plan_row_type row;
      row                       = req_row(op, id, busy);
      row.typed                 = 1'b1;
      row.rsp.send_probe        = probe;
      row.rsp.send_reassign     = reassign;
      row.rsp.send_read_request = readreq;
      row.rsp.response_error    = err;
      row.rsp.miss_count        = misses;
      return row;
   endfunction

   // Random request; tick_pct sets the share of ticks and match_pct how often
   // a live reply carries the expected id.
   function automatic request_type random_request(int unsigned tick_pct,
                                                  int unsigned match_pct);
      request_type r;
      int unsigned roll;
      roll          = $urandom_range(0, 99);
      r.board_id    = BOARD_ID_W'($urandom_range(0, 255));
      r.update_busy = ($urandom_range(0, 9) == 0);
      if (roll < tick_pct) begin
         r.op = OP_TICK;
      end else if (roll < tick_pct + (100 - tick_pct) / 2) begin
         r.op = OP_LIVE;
         if ($urandom_range(0, 99) < match_pct)
            r.board_id = board_cfg.expected_id;
      end else if (roll < 96) begin
         r.op = OP_CHECK;
         if ($urandom_range(0, 99) < 60)
            r.board_id = board_cfg.expected_id;
      end else begin
         r.op = OP_UNUSED;
      end
      return r;
   endfunction

   // Presents one request, waits for it to be taken and queues its response.
   task automatic send_request(request_type r, logic typed, rsp_type typed_rsp);
      int unsigned gap;
      rsp_type     predicted;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= r.op;
      req_board_id    <= r.board_id;
      req_update_busy <= r.update_busy;
      do @(posedge clock); while (!req_ready);
      predicted = monitor_response(r);
      pending_rsp.push_back(typed ? typed_rsp : predicted);
   endtask

   // Stops requesting and waits until every response has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_PRESENT:      board_cfg.present      = d[0];
         CSR_EXPECTED_ID:  board_cfg.expected_id  = d[BOARD_ID_W-1:0];
         CSR_TICK_STEP:    board_cfg.tick_step    = d[TICK_STEP_W-1:0];
         CSR_CHECK_PERIOD: board_cfg.check_period = d;
         default: ;
      endcase
   endtask

   // Writes all four registers once the monitor is idle. Unused upper data
   // bits carry random values, which the monitor must disregard.
   task automatic apply_config(cfg_type c);
      logic [CSR_DATA_W-1:0] junk;
      wait_drained();
      junk = CSR_DATA_W'($urandom_range(0, 16'hFFFF));
      csr_write(CSR_PRESENT, {junk[CSR_DATA_W-1:1], c.present});
      csr_write(CSR_EXPECTED_ID, {junk[CSR_DATA_W-1:BOARD_ID_W], c.expected_id});
      csr_write(CSR_TICK_STEP, {junk[CSR_DATA_W-1:TICK_STEP_W], c.tick_step});
      csr_write(CSR_CHECK_PERIOD, c.check_period);
      csr_valid <= 1'b0;
   endtask

   // Unknown bits in the response count as a mismatch.
   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   // Response side: compares each accepted response and idles at random.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("response accepted with no request outstanding");
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            check_field("send_probe", want.send_probe, rsp_send_probe);
            check_field("send_reassign", want.send_reassign, rsp_send_reassign);
            check_field("send_read_request", want.send_read_request, rsp_send_read_request);
            check_field("response_error", want.response_error, rsp_response_error);
            check_field("miss_count", want.miss_count, rsp_miss_count);
         end
         take_hold = receiver_gap();
      end else if (take_hold > 0) begin
         take_hold--;
      end
      rsp_ready <= (take_hold == 0);
   end

   // Watchdog: ends the run if no handshake completes for too long.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $error("no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   // Stimulus.
   initial begin : stimulus
      cfg_type     c;
      int unsigned tick_pct;
      int unsigned match_pct;
      int unsigned items;
      int unsigned roll;

      board_cfg              = '0;
      board_cfg.tick_step    = TICK_STEP_RESET;
      board_cfg.check_period = CHECK_PERIOD_RESET;
      board_state            = '0;
      alarm_out              = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // With no board present after reset, every request is ignored.
      directed_plan.push_back(typed_row(OP_TICK, 8'h00, 1'b0,
                                        1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
      directed_plan.push_back(typed_row(OP_LIVE, 8'hFF, 1'b1,
                                        1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
      directed_plan.push_back(typed_row(OP_UNUSED, 8'hA5, 1'b0,
                                        1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
      // Zero check period: every tick checks. Misses build up to the alarm.
      directed_plan.push_back(cfg_row(1'b1, 8'h3C, 10'd1, 16'd0));
      directed_plan.push_back(req_row(OP_TICK, 8'h00, 1'b0));
      directed_plan.push_back(req_row(OP_TICK, 8'h00, 1'b0));
      // A busy update only restarts the timer.
      directed_plan.push_back(req_row(OP_TICK, 8'h00, 1'b1));
      directed_plan.push_back(req_row(OP_TICK, 8'h00, 1'b0));
      // A check reply with no probe outstanding is dropped.
      directed_plan.push_back(req_row(OP_CHECK, 8'h3C, 1'b0));
      directed_plan.push_back(req_row(OP_TICK, 8'h00, 1'b0));
      // The fifth miss sends the probe alone.
      directed_plan.push_back(typed_row(OP_TICK, 8'h00, 1'b0,
                                        1'b1, 1'b0, 1'b0, 1'b1, 8'd5));
      directed_plan.push_back(req_row(OP_CHECK, 8'h3C, 1'b0));
      // Five more misses; the answered probe leads to a re-assign.
      repeat (5) directed_plan.push_back(req_row(OP_TICK, 8'h00, 1'b0));
      // A matching live reply releases the alarm.
      directed_plan.push_back(req_row(OP_LIVE, 8'h3C, 1'b0));
      directed_plan.push_back(req_row(OP_TICK, 8'h00, 1'b0));
      directed_plan.push_back(req_row(OP_UNUSED, 8'h5A, 1'b1));
      directed_plan.push_back(req_row(OP_LIVE, 8'hFF, 1'b1));
      // A tick step of 1000 against the smallest non-zero period.
      directed_plan.push_back(cfg_row(1'b1, 8'hFF, 10'd1000, 16'd1));
      directed_plan.push_back(req_row(OP_TICK, 8'h00, 1'b0));
      directed_plan.push_back(req_row(OP_TICK, 8'h00, 1'b0));
      directed_plan.push_back(req_row(OP_TICK, 8'h00, 1'b0));

      foreach (directed_plan[i]) begin
         if (directed_plan[i].is_cfg)
            apply_config(directed_plan[i].cfg);
         else
            send_request(directed_plan[i].req, directed_plan[i].typed, directed_plan[i].rsp);
      end

      // Random phases, each under its own register setting.
      for (int unsigned p = 0; p < NUM_PHASES; p++) begin
         c.present      = 1'b1;
         c.expected_id  = BOARD_ID_W'($urandom_range(0, 255));
         c.tick_step    = TICK_STEP_W'($urandom_range(1, 1000));
         c.check_period = PERIOD_W'($urandom_range(0, 3 * c.tick_step));
         roll           = $urandom_range(0, 2);
         match_pct      = (roll == 0) ? 10 : (roll == 1) ? 50 : 90;
         tick_pct       = 50;
         items          = PHASE_ITEMS;
         case (p)
            0: begin
               // Long runs of misses, enough to saturate the miss count.
               c.tick_step    = 10'd1;
               c.check_period = 16'd0;
               match_pct      = 0;
               tick_pct       = 85;
               items          = STARVE_ITEMS;
            end
            1: begin
               c.tick_step    = 10'd1000;
               c.check_period = 16'd60000;
               tick_pct       = 95;
            end
            2: begin
               // Period at the timer's maximum, reached only once the timer saturates.
               c.tick_step    = 10'd1000;
               c.check_period = ELAPSED_MAX;
               tick_pct       = 95;
            end
            3: c.present = 1'b0;
            4: begin
               c.tick_step    = 10'd1;
               c.check_period = 16'd1;
            end
            5: c.expected_id = 8'h00;
            6: c.expected_id = 8'hFF;
            default: ;
         endcase
         apply_config(c);
         send_calm = (p % 4 == 1);
         take_calm = (p % 3 == 2);
         for (int unsigned i = 0; i < items; i++)
            send_request(random_request(tick_pct, match_pct), 1'b0, '0);
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
